FILE: src/psg_joystick_port_responder_macros.svh
// Assertion helpers shared by the responder sources.
`ifndef PSG_JOYSTICK_PORT_RESPONDER_MACROS_SVH
`define PSG_JOYSTICK_PORT_RESPONDER_MACROS_SVH

// Check cons in the same cycle as ante.
`define PSGJ_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("psgj assertion failed");

// Check cons in the cycle after ante.
`define PSGJ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("psgj assertion failed");

`endif

FILE: src/psgj_pkg.sv
package psgj_pkg;

    typedef enum logic [2:0] {
        ACT_BUS_WRITE = 3'd0,
        ACT_BUS_READ  = 3'd1,
        ACT_MOUNT     = 3'd2,
        ACT_UNMOUNT   = 3'd3,
        ACT_REPORT    = 3'd4
    } t_action;

    localparam logic [7:0] ADDR_PORT   = 8'hA0;
    localparam logic [7:0] WRITE_PORT  = 8'hA1;
    localparam logic [7:0] READ_PORT   = 8'hA2;
    localparam logic [7:0] REG_JOY_IN  = 8'd14;
    localparam logic [7:0] REG_JOY_SEL = 8'd15;
    localparam logic [7:0] IDLE_BYTE   = 8'hFF;
    localparam logic [7:0] ZERO_BYTE   = 8'h00;
    localparam logic [7:0] JOY_MASK    = 8'h3F;
    localparam int         SEL_BIT     = 6;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] io_port;
        logic [7:0] bus_data;
        logic [6:0] device_address;
        logic [3:0] hid_instance;
        logic       descriptor_ok;
        logic [7:0] joy_byte;
    } t_item;

    // Gamepad event handed to the slot table.
    typedef struct packed {
        logic       commit;
        logic       mount;
        logic       unmount;
        logic [6:0] dev;
        logic [3:0] inst;
        logic       desc_ok;
    } t_gp_event;

    // First active slot that matches the event's device.
    typedef struct packed {
        logic hit;
        logic port;
    } t_slot_hit;

endpackage

FILE: src/psgj_slot_table.sv
module psgj_slot_table #(
    parameter int SLOTS = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  psgj_pkg::t_gp_event i_event,
    output psgj_pkg::t_slot_hit o_hit
);
    import psgj_pkg::*;

    `include "psg_joystick_port_responder_macros.svh"

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [SLOTS-1:0] r_active;
    logic [6:0]       r_device [SLOTS];
    logic [3:0]       r_iface  [SLOTS];
    logic [SLOTS-1:0] r_port;

    logic              w_match_any;
    logic [SLOT_W-1:0] w_match_idx;
    logic              w_free_any;
    logic [SLOT_W-1:0] w_free_idx;
    logic              w_used0;
    logic              w_used1;
    logic              w_mount_ok;
    logic              w_unmount_ok;

    // Priority scan: first matching active slot, first inactive slot.
    always_comb begin
        w_match_any = 1'b0;
        w_match_idx = '0;
        w_free_any  = 1'b0;
        w_free_idx  = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (!w_match_any && r_active[i] && r_device[i] == i_event.dev &&
                r_iface[i] == i_event.inst) begin
                w_match_any = 1'b1;
                w_match_idx = SLOT_W'(i);
            end
            if (!w_free_any && !r_active[i]) begin
                w_free_any = 1'b1;
                w_free_idx = SLOT_W'(i);
            end
        end
    end

    assign w_used0 = |(r_active & ~r_port);
    assign w_used1 = |(r_active & r_port);

    assign w_mount_ok   = i_event.commit && i_event.mount && w_free_any &&
                          i_event.desc_ok && !(w_used0 && w_used1);
    assign w_unmount_ok = i_event.commit && i_event.unmount && w_match_any;

    assign o_hit.hit  = w_match_any;
    assign o_hit.port = r_port[w_match_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
        end else if (w_mount_ok) begin
            r_active[w_free_idx] <= 1'b1;
        end else if (w_unmount_ok) begin
            r_active[w_match_idx] <= 1'b0;
        end
    end

    // Slot contents carry no reset; only values of active slots are ever used.
    always_ff @(posedge i_clk) begin
        if (w_mount_ok) begin
            r_device[w_free_idx] <= i_event.dev;
            r_iface[w_free_idx]  <= i_event.inst;
            r_port[w_free_idx]   <= w_used0;
        end
    end

    `PSGJ_ASSERT_SAME(a_two_ports_max, 1'b1, $countones(r_active) <= 2)
    `PSGJ_ASSERT_NEXT(a_mount_adds_slot, w_mount_ok,
        $countones(r_active) == $countones($past(r_active)) + 1)
    `PSGJ_ASSERT_NEXT(a_unmount_frees_slot, w_unmount_ok,
        $countones(r_active) + 1 == $countones($past(r_active)))

endmodule

FILE: src/psg_joystick_port_responder.sv
// Joystick port responder: answers host reads of the sound-chip joystick
// register from gamepad state. Words enter on s_axis and run through an
// input register, combinational execute logic that updates the register
// latch, port select, two port states and the slot table, and a result
// register that feeds m_axis. Only bus reads make a result word
// (data 0 with output-enable mask ~state & 0x3F for a joystick read, else
// data 0xFF with mask 0); writes and gamepad events complete silently. The
// block takes one word per cycle while s_axis_tready is high; a read
// result passes the input register and then the result register before
// it is presented on m_axis. s_axis_tready drops only while a read sits in
// the input register and the result register holds an untaken word.
// No clearing pass follows reset.
module psg_joystick_port_responder #(
    parameter int SLOTS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // io_port[7:0], bus_data[15:8], device_address[22:16],
    // hid_instance[26:23], descriptor_ok[27], joy_byte[35:28], zero[39:36]
    input  logic [39:0] s_axis_tdata,
    // action[2:0]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_data[7:0], oe_mask[15:8]
    output logic [15:0] m_axis_tdata
);
    import psgj_pkg::*;

    `include "psg_joystick_port_responder_macros.svh"

    logic        r_in_valid;
    t_item       r_in;
    logic        r_out_valid;
    logic [15:0] r_out;
    logic [7:0]  r_reg_latch;
    logic        r_port_sel;
    logic [7:0]  r_port_state [2];

    logic        w_is_read;
    logic        w_adv;
    t_gp_event   w_event;
    t_slot_hit   w_hit;
    logic [7:0]  n_read_data;
    logic [7:0]  n_oe_mask;

    // Advance the execute word unless it is a read blocked by a held result.
    assign w_is_read     = (r_in.action == ACT_BUS_READ);
    assign w_adv         = r_in_valid && (!w_is_read || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in.action         <= s_axis_tuser;
            r_in.io_port        <= s_axis_tdata[7:0];
            r_in.bus_data       <= s_axis_tdata[15:8];
            r_in.device_address <= s_axis_tdata[22:16];
            r_in.hid_instance   <= s_axis_tdata[26:23];
            r_in.descriptor_ok  <= s_axis_tdata[27];
            r_in.joy_byte       <= s_axis_tdata[35:28];
        end
    end

    // Gamepad events go to the slot table; it commits only on advance.
    always_comb begin
        w_event.commit  = w_adv;
        w_event.mount   = (r_in.action == ACT_MOUNT);
        w_event.unmount = (r_in.action == ACT_UNMOUNT);
        w_event.dev     = r_in.device_address;
        w_event.inst    = r_in.hid_instance;
        w_event.desc_ok = r_in.descriptor_ok;
    end

    psgj_slot_table #(
        .SLOTS(SLOTS)
    ) u_slots (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_event(w_event),
        .o_hit  (w_hit)
    );

    // Bus registers and port states.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reg_latch     <= ZERO_BYTE;
            r_port_sel      <= 1'b0;
            r_port_state[0] <= IDLE_BYTE;
            r_port_state[1] <= IDLE_BYTE;
        end else if (w_adv) begin
            case (r_in.action)
                ACT_BUS_WRITE: begin
                    if (r_in.io_port == ADDR_PORT) begin
                        r_reg_latch <= r_in.bus_data;
                    end else if (r_in.io_port == WRITE_PORT && r_reg_latch == REG_JOY_SEL) begin
                        r_port_sel <= r_in.bus_data[SEL_BIT];
                    end
                end
                ACT_UNMOUNT: begin
                    if (w_hit.hit) begin
                        r_port_state[w_hit.port] <= IDLE_BYTE;
                    end
                end
                ACT_REPORT: begin
                    if (w_hit.hit) begin
                        r_port_state[w_hit.port] <= r_in.joy_byte;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Read answer: for a joystick read drive low the lines whose joystick bit is active, else release them.
    always_comb begin
        if (r_in.io_port == READ_PORT && r_reg_latch == REG_JOY_IN) begin
            n_read_data = ZERO_BYTE;
            n_oe_mask   = ~r_port_state[r_port_sel] & JOY_MASK;
        end else begin
            n_read_data = IDLE_BYTE;
            n_oe_mask   = ZERO_BYTE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_is_read) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_is_read) begin
            r_out <= {n_oe_mask, n_read_data};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    `PSGJ_ASSERT_NEXT(a_read_gives_word, w_adv && w_is_read, r_out_valid)
    `PSGJ_ASSERT_SAME(a_stall_only_on_read,
        !s_axis_tready, r_in_valid && w_is_read && r_out_valid && !m_axis_tready)
    `PSGJ_ASSERT_SAME(a_answer_shape, r_out_valid,
        (r_out[7:0] == ZERO_BYTE && r_out[15:14] == 2'b00) ||
        (r_out[7:0] == IDLE_BYTE && r_out[15:8] == ZERO_BYTE))

endmodule

FILE: sim/psg_joystick_port_responder_tb.sv
// Testbench for the joystick port responder.
//
// A scoreboard object keeps its own copy of the responder state: register
// latch, port select, the two port states and the gamepad slot table. Every
// word the block accepts on s_axis is run through that copy. For a bus read
// it queues the answer the host should see. Each word taken from m_axis is
// checked, field by field, against the oldest queued answer.
//
// Stimulus starts with a short directed sequence that walks through the
// special cases. Then about 2000 random words follow. Most of them are
// well-formed: register selects on 0xA0, port selects on 0xA1, joystick
// reads on 0xA2, and gamepad events drawn from a small pool of devices so
// that mounts, reports and unmounts hit one another. The rest is noise.
// Both sides idle at random, except in one stretch with no idling. Once,
// the receiver holds off for a long stretch while reads keep arriving, so
// that the block backs up and drops s_axis_tready.
module psg_joystick_port_responder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import psgj_pkg::*;

    localparam int SLOTS       = 4;
    localparam int IDLE_PCT    = 25;
    localparam int WORD_COUNT  = 2000;
    localparam int CALM_FIRST  = 700;
    localparam int CALM_LAST   = 1100;
    localparam int HOLD_FIRST  = 1100;
    localparam int HOLD_LAST   = 1250;
    localparam int HOLD_CYCLES = 300;
    localparam int POOL_SIZE   = 6;
    localparam int DRAIN       = 8;
    localparam int CYCLE_LIMIT = 200000;

    // One answer driven on the bus for a host read.
    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] oe_mask;
    } t_answer;

    // Scoreboard: tracks responder state and the answers still owed.
    class bus_answer_board;
        logic [7:0] reg_latch;
        logic       sel_port;
        logic [7:0] pad_state [2];
        logic       slot_busy [SLOTS];
        logic [6:0] slot_dev  [SLOTS];
        logic [3:0] slot_inst [SLOTS];
        logic       slot_joy  [SLOTS];
        t_answer    answers_due [$];
        int         mismatches;

        function new();
            reg_latch    = ZERO_BYTE;
            sel_port     = 1'b0;
            pad_state[0] = IDLE_BYTE;
            pad_state[1] = IDLE_BYTE;
            for (int i = 0; i < SLOTS; i++) begin
                slot_busy[i] = 1'b0;
                slot_dev[i]  = '0;
                slot_inst[i] = '0;
                slot_joy[i]  = 1'b0;
            end
            mismatches = 0;
        endfunction

        // First active slot holding this gamepad, or -1.
        function int find_pad(logic [6:0] dev, logic [3:0] inst);
            for (int i = 0; i < SLOTS; i++)
                if (slot_busy[i] && slot_dev[i] == dev && slot_inst[i] == inst)
                    return i;
            return -1;
        endfunction

        // Advance the state by one accepted word; queue an answer for reads.
        function void absorb_word(t_item w);
            int      hit;
            int      open_slot;
            bit      taken [2];
            t_answer ans;
            hit       = -1;
            open_slot = -1;
            taken[0]  = 1'b0;
            taken[1]  = 1'b0;
            case (w.action)
                ACT_BUS_WRITE: begin
                    if (w.io_port == ADDR_PORT)
                        reg_latch = w.bus_data;
                    else if (w.io_port == WRITE_PORT && reg_latch == REG_JOY_SEL)
                        sel_port = w.bus_data[SEL_BIT];
                end
                ACT_BUS_READ: begin
                    if (w.io_port == READ_PORT && reg_latch == REG_JOY_IN) begin
                        ans.read_data = ZERO_BYTE;
                        ans.oe_mask   = ~pad_state[sel_port] & JOY_MASK;
                    end else begin
                        // everything else leaves the bus floating
                        ans.read_data = IDLE_BYTE;
                        ans.oe_mask   = ZERO_BYTE;
                    end
                    answers_due.push_back(ans);
                end
                ACT_MOUNT: begin
                    for (int i = SLOTS - 1; i >= 0; i--)
                        if (!slot_busy[i])
                            open_slot = i;
                    for (int i = 0; i < SLOTS; i++)
                        if (slot_busy[i])
                            taken[slot_joy[i]] = 1'b1;
                    // need a free slot, a recognized pad and a free port
                    if (open_slot >= 0 && w.descriptor_ok && !(taken[0] && taken[1])) begin
                        slot_busy[open_slot] = 1'b1;
                        slot_dev[open_slot]  = w.device_address;
                        slot_inst[open_slot] = w.hid_instance;
                        slot_joy[open_slot]  = taken[0];
                    end
                end
                ACT_UNMOUNT: begin
                    hit = find_pad(w.device_address, w.hid_instance);
                    if (hit >= 0) begin
                        pad_state[slot_joy[hit]] = IDLE_BYTE;
                        slot_busy[hit]           = 1'b0;
                    end
                end
                ACT_REPORT: begin
                    hit = find_pad(w.device_address, w.hid_instance);
                    if (hit >= 0)
                        pad_state[slot_joy[hit]] = w.joy_byte;
                end
                default: ;
            endcase
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_answer(logic [7:0] rd, logic [7:0] mask);
            t_answer ans;
            if (answers_due.size() == 0) begin
                report_mismatch($sformatf("unexpected answer data %h mask %h", rd, mask));
            end else begin
                ans = answers_due.pop_front();
                if (rd !== ans.read_data)
                    report_mismatch($sformatf("read_data %h, want %h", rd, ans.read_data));
                if (mask !== ans.oe_mask)
                    report_mismatch($sformatf("oe_mask %h, want %h",
                                              mask, ans.oe_mask));
            end
        endtask

        function int pending();
            return answers_due.size();
        endfunction
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;   // io_port, bus_data, device_address,
                                       // hid_instance, descriptor_ok, joy_byte, zero
    logic [2:0]  s_axis_tuser  = '0;   // action
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // read_data, oe_mask

    bus_answer_board board = new();

    bit          calm      = 1'b0;     // no idling on either side
    int          hold_seq  = 0;        // bump to ask the receiver for a long hold-off
    int          hold_seen = 0;
    int          cycles    = 0;
    logic [6:0]  pool_dev  [POOL_SIZE];
    logic [3:0]  pool_inst [POOL_SIZE];

    psg_joystick_port_responder #(
        .SLOTS(SLOTS)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Abort a hung run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Check every answer word the host takes.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_answer(m_axis_tdata[7:0], m_axis_tdata[15:8]);
    end

    // Receiver: random stalls, a calm stretch, and one long hold-off.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_seq != hold_seen) begin
                hold_seen = hold_seq;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
            end else if (calm) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    function automatic t_item make_word(logic [2:0] action, logic [7:0] port,
                                        logic [7:0] data, logic [6:0] dev,
                                        logic [3:0] inst, logic ok, logic [7:0] joy);
        t_item w;
        w.action         = action;
        w.io_port        = port;
        w.bus_data       = data;
        w.device_address = dev;
        w.hid_instance   = inst;
        w.descriptor_ok  = ok;
        w.joy_byte       = joy;
        return w;
    endfunction

    // Offer one word and hold it until the block takes it; note it at that edge.
    task send_word(t_item w);
        if (!calm) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, w.joy_byte, w.descriptor_ok, w.hid_instance,
                          w.device_address, w.bus_data, w.io_port};
        s_axis_tuser  <= w.action;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        board.absorb_word(w);
    endtask

    // Draw a fresh set of gamepads; keep the extremes in it.
    function void refill_pool();
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_dev[i]  = 7'($urandom);
            pool_inst[i] = 4'($urandom);
        end
        pool_dev[0]  = 7'h7F;
        pool_inst[0] = 4'hF;
        pool_dev[1]  = 7'h00;
        pool_inst[1] = 4'h0;
    endfunction

    // Mostly well-formed traffic with random payload; read_heavy favors reads.
    function automatic t_item random_word(bit read_heavy);
        t_item w;
        int    pick;
        int    roll;
        w    = t_item'({$urandom, $urandom});
        pick = $urandom_range(0, POOL_SIZE - 1);
        roll = read_heavy ? $urandom_range(0, 39) : $urandom_range(0, 99);
        w.device_address = pool_dev[pick];
        w.hid_instance   = pool_inst[pick];
        if (roll < 30) begin
            w.action = ACT_BUS_READ;
            if ($urandom_range(0, 99) < 80)
                w.io_port = READ_PORT;
        end else if (roll < 55) begin
            w.action = ACT_BUS_WRITE;
            roll     = $urandom_range(0, 99);
            if (roll < 40) begin
                w.io_port = ADDR_PORT;
                if ($urandom_range(0, 99) < 70)
                    w.bus_data = $urandom_range(0, 1) ? REG_JOY_IN : REG_JOY_SEL;
            end else if (roll < 80) begin
                w.io_port = WRITE_PORT;
            end
        end else if (roll < 65) begin
            w.action        = ACT_MOUNT;
            w.descriptor_ok = ($urandom_range(0, 99) < 85);
        end else if (roll < 73) begin
            w.action = ACT_UNMOUNT;
            if ($urandom_range(0, 99) < 15) begin
                w.device_address = 7'($urandom);
                w.hid_instance   = 4'($urandom);
            end
        end else if (roll < 90) begin
            w.action = ACT_REPORT;
        end else begin
            // noise: every field random, unused actions included
            w.device_address = 7'($urandom);
            w.hid_instance   = 4'($urandom);
        end
        return w;
    endfunction

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Other read: nothing latched yet.
        send_word(make_word(ACT_BUS_READ, READ_PORT, 8'h00, 7'h00, 4'h0, 1'b0, 8'h00));
        send_word(make_word(ACT_BUS_WRITE, ADDR_PORT, REG_JOY_IN, 7'h7F, 4'hF, 1'b1, 8'hFF));
        // Joystick read with no pad: all lines released.
        send_word(make_word(ACT_BUS_READ, READ_PORT, 8'hFF, 7'h00, 4'h0, 1'b0, 8'h00));
        send_word(make_word(ACT_BUS_READ, WRITE_PORT, 8'h00, 7'h00, 4'h0, 1'b0, 8'h00));
        // Unrecognized pad is ignored, then mounted on port 0.
        send_word(make_word(ACT_MOUNT, 8'h00, 8'h00, 7'h7F, 4'hF, 1'b0, 8'h00));
        send_word(make_word(ACT_MOUNT, 8'hFF, 8'hFF, 7'h7F, 4'hF, 1'b1, 8'h00));
        send_word(make_word(ACT_REPORT, 8'h00, 8'h00, 7'h7F, 4'hF, 1'b0, 8'h00));
        send_word(make_word(ACT_BUS_READ, READ_PORT, 8'h00, 7'h00, 4'h0, 1'b0, 8'hFF));
        // Other write: select port with register 14 latched.
        send_word(make_word(ACT_BUS_WRITE, WRITE_PORT, 8'h40, 7'h00, 4'h0, 1'b0, 8'h00));
        send_word(make_word(ACT_BUS_READ, READ_PORT, 8'h00, 7'h00, 4'h0, 1'b0, 8'h00));
        // Switch to port 1 and mount a second pad there.
        send_word(make_word(ACT_BUS_WRITE, ADDR_PORT, REG_JOY_SEL, 7'h00, 4'h0, 1'b0, 8'h00));
        send_word(make_word(ACT_BUS_WRITE, WRITE_PORT, 8'hFF, 7'h00, 4'h0, 1'b0, 8'h00));
        send_word(make_word(ACT_BUS_WRITE, ADDR_PORT, REG_JOY_IN, 7'h00, 4'h0, 1'b0, 8'h00));
        send_word(make_word(ACT_MOUNT, 8'h00, 8'h00, 7'h00, 4'h0, 1'b1, 8'h00));
        send_word(make_word(ACT_REPORT, 8'h00, 8'h00, 7'h00, 4'h0, 1'b0, 8'hAA));
        send_word(make_word(ACT_BUS_READ, READ_PORT, 8'h00, 7'h00, 4'h0, 1'b0, 8'h00));
        // Both ports taken: a third pad is ignored.
        send_word(make_word(ACT_MOUNT, 8'h00, 8'h00, 7'h05, 4'h3, 1'b1, 8'h00));
        // Unknown device: unmount and report change nothing.
        send_word(make_word(ACT_UNMOUNT, 8'h00, 8'h00, 7'h01, 4'h1, 1'b0, 8'h00));
        send_word(make_word(ACT_REPORT, 8'h00, 8'h00, 7'h01, 4'h1, 1'b0, 8'h00));
        // Free port 1, then a duplicate mount of the first pad lands there;
        // its reports still go to the first matching slot on port 0.
        send_word(make_word(ACT_UNMOUNT, 8'h00, 8'h00, 7'h00, 4'h0, 1'b0, 8'h00));
        send_word(make_word(ACT_MOUNT, 8'h00, 8'h00, 7'h7F, 4'hF, 1'b1, 8'h00));
        send_word(make_word(ACT_REPORT, 8'h00, 8'h00, 7'h7F, 4'hF, 1'b1, 8'h55));
        send_word(make_word(ACT_BUS_READ, READ_PORT, 8'h00, 7'h00, 4'h0, 1'b0, 8'h00));
        // Unused actions.
        for (int a = ACT_REPORT + 1; a < 8; a++)
            send_word(make_word(3'(a), READ_PORT, 8'hFF, 7'h7F, 4'hF, 1'b1, 8'h00));

        for (int n = 0; n < WORD_COUNT; n++) begin
            if (n % 200 == 0)
                refill_pool();
            calm = (n >= CALM_FIRST && n < CALM_LAST);
            if (n == HOLD_FIRST)
                hold_seq++;
            send_word(random_word(n >= HOLD_FIRST && n < HOLD_LAST));
        end
        s_axis_tvalid <= 1'b0;

        // Let the answers still in flight drain.
        while (board.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        if (board.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/psgj_pkg.sv
src/psgj_slot_table.sv
src/psg_joystick_port_responder.sv
sim/psg_joystick_port_responder_tb.sv
